[design/gdb_pkg.sv]
// shared types and constants of the 2x2 box downscaler
// no dependencies; imported by gdb_ctrl, gdb_combine and the top level
package gdb_pkg;

  localparam int MAX_WIDTH_DEF  = 4096;
  localparam int HEIGHT_LIMIT   = 4096;
  localparam int ROW_W          = 12;
  localparam int PIX_W          = 8;
  localparam int SUM_W          = 9;
  localparam int CFG_DATA_W     = 13;
  localparam int CFG_IDX_W      = 1;
  localparam int SRC_WIDTH_RST  = 640;
  localparam int SRC_HEIGHT_RST = 480;

  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 1'b1;

  // how the combine stage forms a result from the item
  typedef enum logic [2:0] {
    OP_NONE,
    OP_PASS,
    OP_PAIR,
    OP_QUAD,
    OP_VERT
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [PIX_W-1:0] pix;
    logic [PIX_W-1:0] left;
    logic             row_end;
    logic             frame_end;
  } item_t;

endpackage

[design/gdb_if.sv]
// stream channels of the downscaler: pixel input and downscaled output
// depends on gdb_pkg for the pixel width
interface gdb_pix_in_if;
  logic                      valid;
  logic                      ready;
  logic [gdb_pkg::PIX_W-1:0] pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink (input valid, input pixel_in, output ready);
endinterface

interface gdb_pix_out_if;
  logic                      valid;
  logic                      ready;
  logic [gdb_pkg::PIX_W-1:0] pixel_out;
  logic                      row_end;
  logic                      frame_end;

  modport source (output valid, output pixel_out, output row_end, output frame_end,
                  input ready);
  modport sink (input valid, input pixel_out, input row_end, input frame_end,
                output ready);
endinterface

[design/gdb_line_ram.sv]
// single-port line store of horizontal pair sums, registered read data
// no package dependencies
module gdb_line_ram #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11,
  parameter int DW    = 9
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic          we_i,
  input  logic [AW-1:0] addr_i,
  input  logic [DW-1:0] wdata_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] line_mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        line_mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= line_mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/gdb_ctrl.sv]
// front stage: size registers, column/row counters, left pixel and line store access
// depends on gdb_pkg
module gdb_ctrl #(
  parameter int MAX_WIDTH = gdb_pkg::MAX_WIDTH_DEF,
  parameter int CW        = $clog2(MAX_WIDTH),
  parameter int AW        = 11
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [gdb_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [gdb_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  logic                                accept_i,
  input  logic [gdb_pkg::PIX_W-1:0]           pixel_i,
  output logic                                mem_en_o,
  output logic                                mem_we_o,
  output logic [AW-1:0]                       mem_addr_o,
  output logic [gdb_pkg::SUM_W-1:0]           mem_wdata_o,
  output logic                                item_valid_o,
  output gdb_pkg::item_t                      item_o
);
  import gdb_pkg::*;

  // last valid index for a size register value, zero taken as one and values above hi as hi
  function automatic int clamp_last(input int v, input int hi);
    int r;
    if (v < 1) r = 0;
    else if (v > hi) r = hi - 1;
    else r = v - 1;
    return r;
  endfunction

  logic [CW-1:0]    col_last_q, col_q, col_d;
  logic [ROW_W-1:0] row_last_q, row_q, row_d;
  logic [PIX_W-1:0] left_q, left_d;
  logic             last_col, last_row, odd_row, odd_col;
  op_e              op;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_last_q <= CW'(clamp_last(SRC_WIDTH_RST, MAX_WIDTH));
      row_last_q <= ROW_W'(clamp_last(SRC_HEIGHT_RST, HEIGHT_LIMIT));
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_SRC_WIDTH:  col_last_q <= CW'(clamp_last(int'(cfg_wdata_i), MAX_WIDTH));
        REG_SRC_HEIGHT: row_last_q <= ROW_W'(clamp_last(int'(cfg_wdata_i), HEIGHT_LIMIT));
      endcase
    end
  end

  always_comb begin
    last_col    = (col_q >= col_last_q);
    last_row    = (row_q >= row_last_q);
    odd_row     = row_q[0];
    odd_col     = col_q[0];
    op          = OP_NONE;
    left_d      = left_q;
    mem_en_o    = 1'b0;
    mem_we_o    = 1'b0;
    mem_addr_o  = AW'(col_q >> 1);
    mem_wdata_o = SUM_W'(left_q) + SUM_W'(pixel_i);

    if (last_row && !odd_row) begin
      // lone last row, paired with itself
      if (odd_col) begin
        op = OP_PAIR;
      end else begin
        left_d = pixel_i;
        if (last_col) op = OP_PASS;
      end
    end else if (!odd_row) begin
      // even row fills the line store
      if (odd_col) begin
        mem_en_o = accept_i;
        mem_we_o = 1'b1;
      end else begin
        left_d = pixel_i;
        if (last_col) begin
          mem_en_o    = accept_i;
          mem_we_o    = 1'b1;
          mem_wdata_o = SUM_W'(pixel_i);
        end
      end
    end else begin
      if (odd_col) begin
        op       = OP_QUAD;
        mem_en_o = accept_i;
      end else begin
        left_d = pixel_i;
        if (last_col) begin
          op       = OP_VERT;
          mem_en_o = accept_i;
        end
      end
    end

    if (last_col) begin
      col_d = '0;
      row_d = last_row ? '0 : ROW_W'(row_q + 1'b1);
    end else begin
      col_d = CW'(col_q + 1'b1);
      row_d = row_q;
    end

    item_valid_o      = accept_i && (op != OP_NONE);
    item_o.op         = op;
    item_o.pix        = pixel_i;
    item_o.left       = left_q;
    item_o.row_end    = last_col;
    item_o.frame_end  = last_col && last_row;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      left_q <= '0;
    end else if (accept_i) begin
      col_q  <= col_d;
      row_q  <= row_d;
      left_q <= left_d;
    end
  end

  a_read_odd_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_en_o && !mem_we_o) |-> row_q[0])
    else $error("line store read outside an odd row");

  a_col_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && last_col) |=> (col_q == '0))
    else $error("column counter did not wrap at row end");

  a_frame_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_valid_o && item_o.frame_end) |-> item_o.row_end)
    else $error("frame end without row end");

endmodule

[design/gdb_combine.sv]
// back stage: combines line store data with the item and holds the output register
// depends on gdb_pkg and gdb_pix_out_if
module gdb_combine (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      load_i,
  input  gdb_pkg::item_t            item_i,
  input  logic [gdb_pkg::SUM_W-1:0] rdata_i,
  output logic                      ready_o,
  gdb_pix_out_if.source             dst
);
  import gdb_pkg::*;

  item_t            s1_q;
  logic             s1_valid_q;
  logic             s1_go;
  logic             out_valid_q;
  logic [PIX_W-1:0] out_pix_q, val;
  logic             out_row_end_q, out_frame_end_q;
  logic [10:0]      quad_sum;
  logic [9:0]       vert_sum;
  logic [8:0]       pair_sum;

  assign s1_go   = s1_valid_q && (!out_valid_q || dst.ready);
  assign ready_o = !s1_valid_q || s1_go;

  always_comb begin
    quad_sum = 11'(rdata_i) + 11'(s1_q.left) + 11'(s1_q.pix) + 11'd2;
    vert_sum = 10'(rdata_i) + 10'(s1_q.pix) + 10'd1;
    pair_sum = 9'(s1_q.left) + 9'(s1_q.pix) + 9'd1;
    case (s1_q.op)
      OP_QUAD: val = quad_sum[9:2];
      OP_VERT: val = vert_sum[8:1];
      OP_PAIR: val = pair_sum[8:1];
      default: val = s1_q.pix;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (ready_o) s1_valid_q <= load_i;
      if (s1_go) out_valid_q <= 1'b1;
      else if (dst.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && load_i) s1_q <= item_i;
    if (s1_go) begin
      out_pix_q       <= val;
      out_row_end_q   <= s1_q.row_end;
      out_frame_end_q <= s1_q.frame_end;
    end
  end

  assign dst.valid     = out_valid_q;
  assign dst.pixel_out = out_pix_q;
  assign dst.row_end   = out_row_end_q;
  assign dst.frame_end = out_frame_end_q;

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_go) |-> !ready_o)
    else $error("combine stage would be overwritten while held");

  a_s1_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_go |=> out_valid_q)
    else $error("item left the combine stage but no output appeared");

endmodule

[design/gray_downscale_2x2_box_top.sv]
// 2x2 box-filter downscaler for 8-bit gray images, top level
// depends on gdb_pkg, gdb_if, gdb_line_ram, gdb_ctrl, gdb_combine
//
// Usage:
//   src_i takes source pixels in raster order, one item per pixel, valid/ready.
//   dst_o gives the half-size image, ceil(W/2) x ceil(H/2) items, each pixel
//   the rounded mean of its 2x2 block, with row_end and frame_end marks.
//   cfg_we_i/cfg_index_i/cfg_wdata_i write src_width (index 0) and
//   src_height (index 1); write them only while no frame is in flight.
// Throughput: one source pixel per cycle if dst_o keeps up; the single-port line
//   store sees at most one access per pixel (write on even rows, read on odd).
// Path: after its last source pixel is accepted, a result is registered in the
//   combine stage (with the line store read), then in the output register.
// Reset: counters start at row 0, column 0; size registers return to
//   640 x 480. The line store is not cleared: every entry is written by an
//   even row before the following odd row reads it.
// Stall: when dst_o is held, one result waits in the output register and one
//   in the combine stage; src_i ready drops only when both are occupied.
module gray_downscale_2x2_box_top #(
  parameter int MAX_WIDTH = gdb_pkg::MAX_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [gdb_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [gdb_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  gdb_pix_in_if.sink                     src_i,
  gdb_pix_out_if.source                  dst_o
);
  import gdb_pkg::*;

  localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
  localparam int AW         = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int CW         = $clog2(MAX_WIDTH);

  logic             accept;
  logic             mem_en, mem_we;
  logic [AW-1:0]    mem_addr;
  logic [SUM_W-1:0] mem_wdata, mem_rdata;
  logic             item_valid;
  item_t            item;
  logic             ready;

  assign src_i.ready = ready;
  assign accept      = src_i.valid && ready;

  gdb_ctrl #(
    .MAX_WIDTH (MAX_WIDTH),
    .CW        (CW),
    .AW        (AW)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .accept_i     (accept),
    .pixel_i      (src_i.pixel_in),
    .mem_en_o     (mem_en),
    .mem_we_o     (mem_we),
    .mem_addr_o   (mem_addr),
    .mem_wdata_o  (mem_wdata),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  gdb_line_ram #(
    .DEPTH (LINE_DEPTH),
    .AW    (AW),
    .DW    (SUM_W)
  ) u_line_ram (
    .clk_i   (clk_i),
    .en_i    (mem_en),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  gdb_combine u_combine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (item_valid),
    .item_i  (item),
    .rdata_i (mem_rdata),
    .ready_o (ready),
    .dst     (dst_o)
  );

endmodule

[tb/tb_top.sv]
// testbench of the 2x2 box downscaler: a predicted pixel stream is checked item by item
// depends on gdb_pkg, gdb_if and gray_downscale_2x2_box_top
`timescale 1ns / 1ps

module tb_top;
  import gdb_pkg::*;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             row_end;
    logic             frame_end;
  } result_t;

  class downscale_scoreboard;
    logic [SUM_W-1:0]      pair_sums [(MAX_WIDTH_DEF + 1) / 2];
    logic [PIX_W-1:0]      left;
    logic [ROW_W-1:0]      col;
    logic [ROW_W-1:0]      row;
    logic [CFG_DATA_W-1:0] width_reg;
    logic [CFG_DATA_W-1:0] height_reg;
    result_t               expected_pixels [$];
    int                    errors;

    function new();
      width_reg  = SRC_WIDTH_RST;
      height_reg = SRC_HEIGHT_RST;
      left       = '0;
      col        = '0;
      row        = '0;
      errors     = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      if (idx == REG_SRC_WIDTH) begin
        width_reg = value;
      end else if (idx == REG_SRC_HEIGHT) begin
        height_reg = value;
      end
    endfunction

    function int unsigned clamp_size(logic [CFG_DATA_W-1:0] v, int unsigned top);
      if (v == 0) return 1;
      if (v > top) return top;
      return v;
    endfunction

    function bit at_frame_start();
      return (col == 0) && (row == 0);
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction

    // one accepted source pixel: update the line store and counters, queue the output pixel
    function void note_pixel(logic [PIX_W-1:0] p);
      int unsigned w, h, idx, val;
      logic        last_col, last_row, odd_col;
      op_e         kind;
      result_t     res;
      w        = clamp_size(width_reg, MAX_WIDTH_DEF);
      h        = clamp_size(height_reg, HEIGHT_LIMIT);
      last_col = (col >= w - 1);
      last_row = (row >= h - 1);
      odd_col  = col[0];
      idx      = col >> 1;
      kind     = OP_NONE;
      val      = 0;
      if (!row[0] && last_row) begin
        // lone last row is paired with itself
        if (odd_col) begin
          kind = OP_PAIR;
        end else begin
          left = p;
          if (last_col) kind = OP_PASS;
        end
      end else if (!row[0]) begin
        if (odd_col) begin
          pair_sums[idx] = left + p;
        end else begin
          left = p;
          if (last_col) pair_sums[idx] = SUM_W'(p);
        end
      end else begin
        if (odd_col) begin
          kind = OP_QUAD;
        end else begin
          left = p;
          if (last_col) kind = OP_VERT;
        end
      end
      case (kind)
        OP_PASS: val = p;
        OP_PAIR: val = (left + p + 1) >> 1;
        OP_QUAD: val = (pair_sums[idx] + left + p + 2) >> 2;
        OP_VERT: val = (pair_sums[idx] + p + 1) >> 1;
        default: val = 0;
      endcase
      if (last_col) begin
        col = '0;
        row = last_row ? '0 : row + 1'b1;
      end else begin
        col = col + 1'b1;
      end
      if (kind != OP_NONE) begin
        res.pix       = val[PIX_W-1:0];
        res.row_end   = last_col;
        res.frame_end = last_col && last_row;
        expected_pixels.push_back(res);
      end
    endfunction

    task report(string msg);
      $display("%0t mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic [PIX_W-1:0] pix, logic row_end, logic frame_end);
      result_t want;
      if (expected_pixels.size() == 0) begin
        report($sformatf("unexpected output pixel %0d", pix));
      end else begin
        want = expected_pixels.pop_front();
        if (pix !== want.pix)
          report($sformatf("pixel_out %0d, predicted %0d", pix, want.pix));
        if (row_end !== want.row_end)
          report($sformatf("row_end %b, predicted %b", row_end, want.row_end));
        if (frame_end !== want.frame_end)
          report($sformatf("frame_end %b, predicted %b", frame_end, want.frame_end));
      end
    endtask
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  gdb_pix_in_if  src_if ();
  gdb_pix_out_if dst_if ();

  gray_downscale_2x2_box_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .src_i       (src_if),
    .dst_o       (dst_if)
  );

  downscale_scoreboard sb = new();

  int src_idle_pct = 0;
  int dst_idle_pct = 0;
  bit calm         = 1'b0;
  bit long_hold    = 1'b0;
  int pix_mode     = 0;
  int pixels_sent  = 0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("FAIL");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && dst_if.valid && dst_if.ready)
      sb.check_result(dst_if.pixel_out, dst_if.row_end, dst_if.frame_end);
  end

  // output side: random stalls, plus one long hold-off on request
  initial begin
    dst_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (long_hold) begin
        long_hold = 1'b0;
        dst_if.ready <= 1'b0;
        repeat (80) @(posedge clk_i);
      end else if (!calm && $urandom_range(0, 99) < dst_idle_pct) begin
        dst_if.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
      end
      dst_if.ready <= 1'b1;
    end
  end

  function logic [PIX_W-1:0] next_pixel();
    case (pix_mode)
      1:       return '1;
      2:       return '0;
      default: return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_pixel(input logic [PIX_W-1:0] p);
    if (!calm && $urandom_range(0, 99) < src_idle_pct) begin
      src_if.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    src_if.valid    <= 1'b1;
    src_if.pixel_in <= p;
    do @(posedge clk_i); while (src_if.ready !== 1'b1);
    sb.note_pixel(p);
    pixels_sent++;
  endtask

  // stop sending and let every predicted pixel come out, then cover the pipeline
  task automatic drain();
    src_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    sb.set_reg(idx, value);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_frame(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h);
    write_reg(REG_SRC_WIDTH, w);
    write_reg(REG_SRC_HEIGHT, h);
    do send_pixel(next_pixel()); while (!sb.at_frame_start());
  endtask

  initial begin : stimulus
    logic [PIX_W-1:0] corner_img [9] = '{8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0,
                                         8'd255, 8'd255, 8'd0};
    logic [CFG_DATA_W-1:0] w, h;
    int base, total, cut;
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_index_i     = REG_SRC_WIDTH;
    cfg_wdata_i     = '0;
    src_if.valid    = 1'b0;
    src_if.pixel_in = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // odd width and odd height: full block, vertical pair, row pair and lone corner pixel
    write_reg(REG_SRC_WIDTH, 3);
    write_reg(REG_SRC_HEIGHT, 3);
    foreach (corner_img[i]) send_pixel(corner_img[i]);
    // full and near-zero 2x2 blocks
    write_reg(REG_SRC_WIDTH, 2);
    write_reg(REG_SRC_HEIGHT, 2);
    repeat (4) send_pixel(8'd255);
    send_pixel(8'd0);
    send_pixel(8'd0);
    send_pixel(8'd0);
    send_pixel(8'd1);
    // zero sizes are taken as one: a single pixel passes through
    write_reg(REG_SRC_WIDTH, 0);
    write_reg(REG_SRC_HEIGHT, 0);
    send_pixel(8'd200);
    write_reg(REG_SRC_WIDTH, 1);
    write_reg(REG_SRC_HEIGHT, 2);
    send_pixel(8'd0);
    send_pixel(8'd255);

    // output held off long enough to back up the input
    src_idle_pct = 0;
    dst_idle_pct = 0;
    write_reg(REG_SRC_WIDTH, 13'd16);
    write_reg(REG_SRC_HEIGHT, 13'd8);
    long_hold = 1'b1;
    do send_pixel(next_pixel()); while (!sb.at_frame_start());

    base = pixels_sent;
    while (pixels_sent - base < 400) begin
      calm     = (pixels_sent - base >= 320);
      pix_mode = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : 0;
      if ($urandom_range(0, 3) == 0) begin
        src_idle_pct = 0;
        dst_idle_pct = 0;
      end else begin
        src_idle_pct = $urandom_range(10, 50);
        dst_idle_pct = $urandom_range(10, 50);
      end
      w = CFG_DATA_W'(($urandom_range(0, 14) == 0) ? $urandom_range(13, 64)
                                                   : $urandom_range(0, 12));
      h = CFG_DATA_W'(($urandom_range(0, 14) == 0) ? $urandom_range(7, 12)
                                                   : $urandom_range(0, 6));
      total = ((w == 0) ? 1 : w) * ((h == 0) ? 1 : h);
      if (total > 1 && $urandom_range(0, 6) == 0) begin
        // size shrinks in the middle of a frame, then that frame is finished
        write_reg(REG_SRC_WIDTH, w);
        write_reg(REG_SRC_HEIGHT, h);
        cut = $urandom_range(1, total - 1);
        repeat (cut) send_pixel(next_pixel());
        // never grow: an odd row must only read sums its even row wrote
        if ($urandom_range(0, 1) == 0)
          write_reg(REG_SRC_WIDTH, CFG_DATA_W'($urandom_range(0, int'(w))));
        else
          write_reg(REG_SRC_HEIGHT, CFG_DATA_W'($urandom_range(0, int'(h))));
        do send_pixel(next_pixel()); while (!sb.at_frame_start());
      end else begin
        run_frame(w, h);
      end
    end

    drain();
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[files.f]
design/gdb_pkg.sv
design/gdb_if.sv
design/gdb_line_ram.sv
design/gdb_ctrl.sv
design/gdb_combine.sv
design/gray_downscale_2x2_box_top.sv
tb/tb_top.sv
